FILE: hdl/kde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kde_pkg: shared types and constants for the kernel density evaluator
// Opcodes, register indexes, kernel norms, pipeline token and Gaussian table
// generator.
// ----------------------------------------------------------------------------
package kde_pkg;

  localparam int MAX_SAMPLES_DEF     = 1024;
  localparam int MAX_DIMS_DEF        = 4;
  localparam int EXP_TABLE_DEPTH_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IDX_W      = 16;
  localparam int CELLS_MAX  = 4;

  localparam logic [1:0] OP_LOAD_COORD  = 2'd0;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_CNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BW_0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BW_1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BW_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BW_3   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WSI        = 3'd7;

  localparam logic       KERNEL_GAUSS = 1'b0;
  localparam logic       KERNEL_EPAN  = 1'b1;
  localparam logic [14:0] NORM_GAUSS  = 15'd13072;
  localparam logic [14:0] NORM_EPAN   = 15'd24576;
  localparam logic [63:0] E_INV_Q32   = 64'd1580030168;
  localparam logic [15:0] WEIGHT_ONE  = 16'd32768;
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [47:0] SAT48       = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] P_ONE       = 32'd65536;

  // one sample moving down the cell chain
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       p;
  } tok_t;

  // store writes decoded from an accepted request
  typedef struct packed {
    logic              coord_we;
    logic              weight_we;
    logic              query_we;
    logic [IDX_W-1:0]  sidx;
    logic [1:0]        didx;
    logic [15:0]       coord;
    logic [15:0]       weight;
  } load_t;

  typedef struct packed {
    logic        clearing;
    logic        res_valid;
    logic [31:0] density;
  } acc_stat_t;

  // exp(-t) in Q32 rounded to Q1.15, used for table contents at elaboration
  function automatic logic [15:0] gauss_from_t(input logic [63:0] t);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    n    = t >> 32;
    f    = t & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    sum  = term;
    for (int i = 1; i <= 14; i++) begin
      term = ((term * f) >> 32) / 64'(i);
      if ((i % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (64'(i) < n && sum != 64'd0) begin
        sum = (sum * E_INV_Q32) >> 32;
      end
    end
    v = (sum + (64'd1 << 16)) >> 17;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/kde_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kde_cell: one dimension of the product kernel
// Holds the sample coordinates and query coordinate of its dimension, forms
// the scaled kernel factor and multiplies it into the running product.
// ----------------------------------------------------------------------------
module kde_cell #(
  parameter int MAX_SAMPLES     = 1024,
  parameter int EXP_TABLE_DEPTH = 1024,
  parameter int CELL_ID         = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kde_pkg::load_t ld_i,
  input  logic           enable_i,
  input  logic           kernel_sel_i,
  input  logic [23:0]    inv_bw_i,
  input  kde_pkg::tok_t  tok_i,
  output kde_pkg::tok_t  tok_o
);
  import kde_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int TW = $clog2(EXP_TABLE_DEPTH);
  localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int GW = 40 + DW;
  localparam logic [63:0] D2 = 64'(EXP_TABLE_DEPTH) * 64'(EXP_TABLE_DEPTH);
  localparam int NS = 7;

  logic [15:0] mem [MAX_SAMPLES];
  logic [15:0] gtab [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] TK = ((64'(k) * 64'(k)) << 37) / D2;
    assign gtab[k] = gauss_from_t(TK);
  end

  logic [31:0]    wr_idx;
  logic [15:0]    query_q;
  logic [15:0]    coord_q;
  logic [15:0]    mag_q;
  logic [39:0]    ymag_q;
  logic [TW-1:0]  gidx_q;
  logic           g_ok_q;
  logic [47:0]    y2_q;
  logic           e_ok_q;
  logic [15:0]    k_q;
  logic [15:0]    nk_q;
  logic [24:0]    f_q;
  tok_t           tok_q [NS];
  tok_t           out_q;

  logic signed [16:0] diff;
  logic [16:0]        mag_abs;
  logic [GW-1:0]      gprod;
  logic [GW-1:0]      gsh;
  logic [48:0]        epan;
  logic [15:0]        k_d;
  logic [14:0]        norm;
  logic [56:0]        pprod;
  logic [56:0]        psh;
  logic [31:0]        p_d;

  assign wr_idx = 32'(ld_i.sidx);

  always_ff @(posedge clk_i) begin
    if (ld_i.coord_we && ld_i.didx == 2'(CELL_ID) && wr_idx < MAX_SAMPLES) begin
      mem[wr_idx[AW-1:0]] <= ld_i.coord;
    end
    coord_q <= mem[tok_i.idx[AW-1:0]];
  end

  always_comb begin
    diff    = $signed({query_q[15], query_q}) - $signed({coord_q[15], coord_q});
    mag_abs = diff[16] ? 17'(-diff) : 17'(diff);
    gprod   = GW'(ymag_q) * GW'(EXP_TABLE_DEPTH);
    gsh     = gprod >> 27;
    epan    = ((49'd1 << 48) - 49'(y2_q)) >> 33;
    if (kernel_sel_i == KERNEL_EPAN) begin
      k_d = e_ok_q ? epan[15:0] : 16'd0;
    end else begin
      k_d = g_ok_q ? gtab[gidx_q] : 16'd0;
    end
    norm  = (kernel_sel_i == KERNEL_EPAN) ? NORM_EPAN : NORM_GAUSS;
    pprod = 57'(tok_q[NS-1].p) * 57'(f_q);
    psh   = pprod >> 16;
    if (!enable_i) begin
      p_d = tok_q[NS-1].p;
    end else if (psh[56:32] != 25'd0) begin
      p_d = SAT32;
    end else begin
      p_d = psh[31:0];
    end
  end

  // kernel factor pipeline, payload only
  always_ff @(posedge clk_i) begin
    if (ld_i.query_we && ld_i.didx == 2'(CELL_ID)) begin
      query_q <= ld_i.coord;
    end
    mag_q  <= mag_abs[15:0];
    ymag_q <= 40'(mag_q) * 40'(inv_bw_i);
    gidx_q <= gsh[TW-1:0];
    g_ok_q <= gsh < GW'(EXP_TABLE_DEPTH);
    y2_q   <= 48'(ymag_q[23:0]) * 48'(ymag_q[23:0]);
    e_ok_q <= ymag_q[39:24] == 16'd0;
    k_q    <= k_d;
    nk_q   <= 16'((31'(k_q) * 31'(norm)) >> 15);
    f_q    <= 25'((40'(nk_q) * 40'(inv_bw_i)) >> 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        tok_q[i] <= '0;
      end
      out_q <= '0;
    end else begin
      tok_q[0] <= tok_i;
      for (int i = 1; i < NS; i++) begin
        tok_q[i] <= tok_q[i-1];
      end
      out_q <= {tok_q[NS-1].valid, tok_q[NS-1].last, tok_q[NS-1].idx, p_d};
    end
  end

  assign tok_o = out_q;

endmodule
`default_nettype wire

FILE: hdl/kde_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kde_accum: weighting, accumulation and final scaling
// Owns the weight store and its clearing pass, sums weighted products and
// scales the sum by the inverse weight sum.
// ----------------------------------------------------------------------------
module kde_accum #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kde_pkg::load_t     ld_i,
  input  kde_pkg::tok_t      tok_i,
  input  logic               start_i,
  input  logic [31:0]        wsi_i,
  input  logic               take_i,
  output kde_pkg::acc_stat_t stat_o
);
  import kde_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [15:0]   wmem [MAX_SAMPLES];
  logic [31:0]   wr_idx;
  logic          clearing_q;
  logic [AW-1:0] clr_cnt_q;
  logic [15:0]   w_q;
  logic [31:0]   pa_q;
  logic          va_q, la_q;
  logic [32:0]   term_q;
  logic          vb_q, lb_q;
  logic [47:0]   acc_q;
  logic          fin_q, f2_q;
  logic [55:0]   hi_q, lo_q;
  logic          res_valid_q;
  logic [31:0]   density_q;

  logic [48:0]   acc_sum;
  logic [40:0]   r_sum;
  logic [31:0]   dens_d;

  assign wr_idx = 32'(ld_i.sidx);

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      wmem[clr_cnt_q] <= WEIGHT_ONE;
    end else if (ld_i.weight_we && wr_idx < MAX_SAMPLES) begin
      wmem[wr_idx[AW-1:0]] <= ld_i.weight;
    end
    w_q <= wmem[tok_i.idx[AW-1:0]];
  end

  // weight store reset sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(MAX_SAMPLES - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_comb begin
    acc_sum = 49'(acc_q) + 49'(term_q);
    r_sum   = 41'({hi_q[23:0], 8'd0}) + 41'(lo_q >> 16);
    if (hi_q[55:24] != 32'd0 || r_sum[40:32] != 9'd0) begin
      dens_d = SAT32;
    end else begin
      dens_d = r_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= tok_i.p;
    term_q <= 33'((48'(pa_q) * 48'(w_q)) >> 15);
    hi_q   <= 56'(acc_q[47:24]) * 56'(wsi_i);
    lo_q   <= 56'(acc_q[23:0]) * 56'(wsi_i);
    if (f2_q) begin
      density_q <= dens_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      la_q        <= 1'b0;
      vb_q        <= 1'b0;
      lb_q        <= 1'b0;
      acc_q       <= '0;
      fin_q       <= 1'b0;
      f2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      va_q  <= tok_i.valid;
      la_q  <= tok_i.last;
      vb_q  <= va_q;
      lb_q  <= la_q;
      fin_q <= lb_q;
      f2_q  <= fin_q;
      if (start_i) begin
        acc_q <= '0;
      end else if (vb_q) begin
        acc_q <= (acc_sum > 49'(SAT48)) ? SAT48 : acc_sum[47:0];
      end
      if (f2_q) begin
        res_valid_q <= 1'b1;
      end else if (take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.clearing  = clearing_q;
  assign stat_o.res_valid = res_valid_q;
  assign stat_o.density   = density_q;

endmodule
`default_nettype wire

FILE: hdl/kernel_density_evaluation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kernel_density_evaluation: weighted product-kernel density estimator
// Sample store, chain of per-dimension kernel cells and weighted accumulator.
// ----------------------------------------------------------------------------
// Load requests and query coordinates without last_dim do not hold off the
// next request. A query request with last_dim set walks the stored samples
// one per cycle through a chain of one cell per dimension (eight stages
// each), then the weight and accumulate stages and the two-stage final
// scaling. Requests are held off during the walk. After reset the weight
// store is swept to 1.0, during which no request is taken; configuration
// writes are taken at any time.
module kernel_density_evaluation #(
  parameter int MAX_SAMPLES     = kde_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_DIMS        = kde_pkg::MAX_DIMS_DEF,
  parameter int EXP_TABLE_DEPTH = kde_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kde_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kde_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [9:0]                     sample_index_i,
  input  logic [1:0]                     dim_index_i,
  input  logic signed [15:0]             coord_value_i,
  input  logic [15:0]                    weight_value_i,
  input  logic                           last_dim_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    density_o
);
  import kde_pkg::*;

  localparam int NCELLS = (MAX_DIMS < CELLS_MAX) ? MAX_DIMS : CELLS_MAX;
  localparam int CW     = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic        kernel_sel_q;
  logic [10:0] sample_cnt_q;
  logic [2:0]  dim_cnt_q;
  logic [23:0] inv_bw_q [CELLS_MAX];
  logic [31:0] wsi_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        out_valid_q;
  logic [31:0] density_q;

  logic        in_acc;
  logic        start;
  logic        take;
  logic [31:0] ns_full;
  logic [CW-1:0] ns;
  logic [2:0]  nd;
  load_t       ld;
  tok_t        issue;
  tok_t        chain [NCELLS+1];
  acc_stat_t   stat;

  assign in_stall_o = (state_q != ST_IDLE) || stat.clearing;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && opcode_i == OP_QUERY && last_dim_i;
  assign take       = stat.res_valid && (!out_valid_q || !out_stall_i);

  assign ns_full = (32'(sample_cnt_q) > MAX_SAMPLES) ? 32'(MAX_SAMPLES) : 32'(sample_cnt_q);
  assign ns      = ns_full[CW-1:0];
  assign nd      = (32'(dim_cnt_q) > NCELLS) ? 3'(NCELLS) : dim_cnt_q;

  always_comb begin
    ld.coord_we  = in_acc && opcode_i == OP_LOAD_COORD && 32'(dim_index_i) < MAX_DIMS;
    ld.weight_we = in_acc && opcode_i == OP_LOAD_WEIGHT;
    ld.query_we  = in_acc && opcode_i == OP_QUERY && 32'(dim_index_i) < MAX_DIMS;
    ld.sidx      = IDX_W'(sample_index_i);
    ld.didx      = dim_index_i;
    ld.coord     = coord_value_i;
    ld.weight    = weight_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_sel_q <= KERNEL_GAUSS;
      sample_cnt_q <= 11'd1;
      dim_cnt_q    <= 3'd1;
      for (int i = 0; i < CELLS_MAX; i++) begin
        inv_bw_q[i] <= 24'd65536;
      end
      wsi_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KERNEL_SEL: kernel_sel_q <= cfg_data_i[0];
        REG_SAMPLE_CNT: sample_cnt_q <= cfg_data_i[10:0];
        REG_DIM_CNT:    dim_cnt_q    <= cfg_data_i[2:0];
        REG_INV_BW_0:   inv_bw_q[0]  <= cfg_data_i[23:0];
        REG_INV_BW_1:   inv_bw_q[1]  <= cfg_data_i[23:0];
        REG_INV_BW_2:   inv_bw_q[2]  <= cfg_data_i[23:0];
        REG_INV_BW_3:   inv_bw_q[3]  <= cfg_data_i[23:0];
        REG_WSI:        wsi_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sample walk sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue       = '0;
    issue.p     = P_ONE;
    issue.idx   = IDX_W'(cnt_q);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cnt_q < ns) begin
          issue.valid = 1'b1;
          issue.last  = (cnt_q == ns - 1'b1);
          cnt_d       = cnt_q + 1'b1;
        end else begin
          // no samples in use: empty request just closes the sum
          issue.last = 1'b1;
        end
        if (issue.last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (take) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      density_q <= stat.density;
    end
  end

  assign chain[0] = issue;

  for (genvar d = 0; d < NCELLS; d++) begin : g_cell
    kde_cell #(
      .MAX_SAMPLES    (MAX_SAMPLES),
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
      .CELL_ID        (d)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ld_i        (ld),
      .enable_i    (3'(d) < nd),
      .kernel_sel_i(kernel_sel_q),
      .inv_bw_i    (inv_bw_q[d]),
      .tok_i       (chain[d]),
      .tok_o       (chain[d+1])
    );
  end

  kde_accum #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld),
    .tok_i  (chain[NCELLS]),
    .start_i(start),
    .wsi_i  (wsi_q),
    .take_i (take),
    .stat_o (stat)
  );

  assign out_valid_o = out_valid_q;
  assign density_o   = density_q;

endmodule
`default_nettype wire

FILE: hdl/kde_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kde_checker: port-level checks for the kernel density evaluator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module kde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  opcode_i,
  input logic        last_dim_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] density_o
);
  import kde_pkg::*;

  logic start;
  assign start = in_valid_i && !in_stall_o && opcode_i == OP_QUERY && last_dim_i;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(density_o))
    else $error("density changed while stalled");

  // the sample walk blocks further requests
  a_walk_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("request taken during sample walk");

  // the pipeline cannot produce a density right after the query
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !$rose(out_valid_o))
    else $error("density appeared too early");

  // weight sweep holds off requests after reset
  a_sweep: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request possible during weight sweep");

endmodule

bind kernel_density_evaluation kde_checker u_kde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .opcode_i   (opcode_i),
  .last_dim_i (last_dim_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .density_o  (density_o)
);
`default_nettype wire

FILE: verif/kernel_density_evaluation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_density_evaluation_tb: self-checking bench for the density evaluator
// Drives load and query requests with random gaps and output stalls, predicts
// every density from an internal bit-exact model and compares each result.
// ----------------------------------------------------------------------------
module kernel_density_evaluation_tb;
  import kde_pkg::*;

  localparam int NSMP = 1024;
  localparam int NDIM = 4;
  localparam int TBL_DEPTH = 1024;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 1100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [9:0]  sample_index_i = '0;
  logic [1:0]  dim_index_i = '0;
  logic signed [15:0] coord_value_i = '0;
  logic [15:0] weight_value_i = '0;
  logic        last_dim_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] density_o;

  kernel_density_evaluation dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .opcode_i, .sample_index_i, .dim_index_i,
    .coord_value_i, .weight_value_i, .last_dim_i,
    .out_valid_o, .out_stall_i, .density_o
  );

  // shadow of the block's state
  logic        sh_kernel;
  logic [10:0] sh_samples;
  logic [2:0]  sh_dims;
  logic [23:0] sh_inv_bw [NDIM];
  logic [31:0] sh_wsi;
  logic [15:0] sh_coord [NSMP*NDIM];
  logic [15:0] sh_weight [NSMP];
  logic [15:0] sh_query [NDIM];
  logic [15:0] exp_tbl [TBL_DEPTH];
  bit          coord_known [NSMP*NDIM];
  bit          query_known [NDIM];

  logic [31:0] density_q [$];
  int          errors = 0;
  int          req_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  longint      cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("kernel_density_evaluation_tb: errors");
      $finish;
    end
  end

  // exp(-t), t and result in Q32
  function automatic logic [63:0] exp_neg(input logic [63:0] t);
    logic [63:0] whole, frac, term, acc;
    whole = t >> 32;
    frac  = t & 64'hFFFF_FFFF;
    term  = 64'd1 << 32;
    acc   = term;
    for (int i = 1; i <= 14; i++) begin
      term = ((term * frac) >> 32) / 64'(i);
      acc = (i % 2 == 1) ? acc - term : acc + term;
    end
    for (longint i = 0; i < whole && acc != 0; i++) acc = (acc * E_INV_Q32) >> 32;
    return acc;
  endfunction

  function automatic logic [63:0] kernel_of(input logic [63:0] ymag);
    logic [63:0] slot;
    if (sh_kernel == KERNEL_EPAN) begin
      if (ymag >= (64'd1 << 24)) return 0;
      return ((64'd1 << 48) - ymag * ymag) >> 33;
    end
    slot = (ymag * TBL_DEPTH) >> 27;
    if (slot >= TBL_DEPTH) return 0;
    return 64'(exp_tbl[slot]);
  endfunction

  function automatic logic [31:0] predict_density();
    int ns, nd, diff;
    logic [63:0] norm, p, mag, nk, f, acc, hi, lo, t1, r;
    ns = (sh_samples > NSMP) ? NSMP : int'(sh_samples);
    nd = (sh_dims > NDIM) ? NDIM : int'(sh_dims);
    norm = (sh_kernel == KERNEL_EPAN) ? 64'(NORM_EPAN) : 64'(NORM_GAUSS);
    acc = 0;
    for (int s = 0; s < ns; s++) begin
      p = 65536;
      for (int d = 0; d < nd; d++) begin
        diff = int'($signed(sh_query[d])) - int'($signed(sh_coord[s*NDIM+d]));
        mag = 64'(diff < 0 ? -diff : diff);
        nk = (kernel_of(mag * sh_inv_bw[d]) * norm) >> 15;
        f = (nk * sh_inv_bw[d]) >> 15;
        p = (p * f) >> 16;
        if (p > SAT32) p = SAT32;
      end
      acc = acc + ((p * sh_weight[s]) >> 15);
      if (acc > SAT48) acc = SAT48;
    end
    hi = acc >> 24;
    lo = acc & 64'hFF_FFFF;
    t1 = hi * sh_wsi;
    if (t1 >= (64'd1 << 24)) return SAT32;
    r = (t1 << 8) + ((lo * sh_wsi) >> 16);
    return (r > SAT32) ? SAT32 : r[31:0];
  endfunction

  initial begin
    logic [63:0] t, v;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      t = ((64'(k) * 64'(k)) << 37) / (64'(TBL_DEPTH) * TBL_DEPTH);
      v = (exp_neg(t) + (64'd1 << 16)) >> 17;
      exp_tbl[k] = (v > 32768) ? 16'd32768 : v[15:0];
    end
    sh_kernel = KERNEL_GAUSS;
    sh_samples = 1;
    sh_dims = 1;
    for (int d = 0; d < NDIM; d++) sh_inv_bw[d] = 24'd65536;
    sh_wsi = 32'd65536;
    for (int s = 0; s < NSMP; s++) sh_weight[s] = WEIGHT_ONE;
  end

  // ---------------- sender side ----------------

  task automatic send_req(input logic [1:0] op, input logic [9:0] sidx,
                          input logic [1:0] didx, input logic [15:0] coord,
                          input logic [15:0] wt, input logic last);
    bit taken;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    sample_index_i <= sidx;
    dim_index_i    <= didx;
    coord_value_i  <= coord;
    weight_value_i <= wt;
    last_dim_i     <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    req_count++;
    case (op)
      OP_LOAD_COORD: begin
        sh_coord[sidx*NDIM+didx] = coord;
        coord_known[sidx*NDIM+didx] = 1'b1;
      end
      OP_LOAD_WEIGHT: sh_weight[sidx] = wt;
      OP_QUERY: begin
        sh_query[didx] = coord;
        query_known[didx] = 1'b1;
        if (last) density_q.push_back(predict_density());
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (density_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KERNEL_SEL: sh_kernel = val[0];
      REG_SAMPLE_CNT: sh_samples = val[10:0];
      REG_DIM_CNT:    sh_dims = val[2:0];
      REG_INV_BW_0, REG_INV_BW_1, REG_INV_BW_2, REG_INV_BW_3:
        sh_inv_bw[idx - REG_INV_BW_0] = val[23:0];
      default:        sh_wsi = val;
    endcase
  endtask

  task automatic set_all(input logic ks, input int sc, input int dc,
                         input logic [23:0] bw, input logic [31:0] wsi);
    wait_idle();
    write_reg(REG_KERNEL_SEL, 32'(ks));
    write_reg(REG_SAMPLE_CNT, 32'(sc));
    write_reg(REG_DIM_CNT, 32'(dc));
    for (int d = 0; d < NDIM; d++) begin
      write_reg(REG_INV_BW_0 + CFG_IDX_W'(d),
                32'((d == 0) ? bw : 24'($urandom_range(32'h3_0000, 32'h4000))));
    end
    write_reg(REG_WSI, wsi);
  endtask

  function automatic logic [15:0] near_coord();
    return 16'($urandom_range(1023)) - 16'd512;
  endfunction

  function automatic logic [15:0] rand_weight();
    return ($urandom_range(7) == 0) ? WEIGHT_ONE : 16'($urandom_range(32768));
  endfunction

  // make sure every coordinate the next walk reads has been written
  task automatic fill_missing();
    int ns, nd;
    ns = (sh_samples > NSMP) ? NSMP : int'(sh_samples);
    nd = (sh_dims > NDIM) ? NDIM : int'(sh_dims);
    for (int s = 0; s < ns; s++)
      for (int d = 0; d < nd; d++)
        if (!coord_known[s*NDIM+d])
          send_req(OP_LOAD_COORD, 10'(s), 2'(d), near_coord(), 16'($urandom), 1'b0);
  endtask

  // query coordinates for all dims in use, random order, last one starts the walk
  task automatic query_point(input bit wild);
    int nd, order [NDIM];
    nd = (sh_dims > NDIM) ? NDIM : int'(sh_dims);
    if (nd == 0) nd = 1;
    for (int d = 0; d < NDIM; d++) order[d] = d;
    for (int d = nd - 1; d > 0; d--) begin
      int j, tmp;
      j = $urandom_range(d);
      tmp = order[d]; order[d] = order[j]; order[j] = tmp;
    end
    for (int d = 0; d < nd; d++)
      send_req(OP_QUERY, 10'($urandom), 2'(order[d]),
               wild ? 16'($urandom) : near_coord(), 16'($urandom), d == nd - 1);
  endtask

  // ---------------- receiver side ----------------

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(4) == 0) begin
        stall_left = $urandom_range(13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (density_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected density, expected none, actual %h", $time, density_o);
      end else begin
        logic [31:0] want;
        want = density_q.pop_front();
        if (density_o !== want) begin
          errors++;
          $display("%0t: density mismatch, expected %h, actual %h", $time, want, density_o);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_reset_state();
    // reset config, one sample, one dim, weight from the reset sweep
    send_req(OP_LOAD_COORD, 10'd0, 2'd0, 16'h0100, 16'h0, 1'b0);
    send_req(OP_QUERY, 10'd0, 2'd0, 16'h0100, 16'h0, 1'b1);
    send_req(OP_QUERY, 10'd0, 2'd0, 16'h0180, 16'h0, 1'b1);
  endtask

  task automatic test_extremes();
    set_all(KERNEL_GAUSS, 2, 4, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_LOAD_WEIGHT, 10'd1023, 2'd3, 16'h7FFF, 16'hFFFF, 1'b1);
    send_req(OP_LOAD_WEIGHT, 10'd0, 2'd0, 16'h0, WEIGHT_ONE, 1'b0);
    send_req(OP_LOAD_WEIGHT, 10'd1, 2'd0, 16'h0, 16'h0, 1'b0);
    for (int d = 0; d < NDIM; d++) begin
      send_req(OP_LOAD_COORD, 10'd0, 2'(d), 16'h8000, 16'h0, 1'b1);
      send_req(OP_LOAD_COORD, 10'd1, 2'(d), 16'h7FFF, 16'h0, 1'b0);
    end
    send_req(OP_LOAD_COORD, 10'd1023, 2'd3, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int d = 0; d < NDIM; d++) send_req(OP_QUERY, 10'd1023, 2'(d), 16'h8000, 16'h0, d == 3);
    send_req(OP_QUERY, 10'd0, 2'd0, 16'h7FFF, 16'h0, 1'b1);
    set_all(KERNEL_EPAN, 2, 7, 24'h0, 32'h0);
    send_req(OP_QUERY, 10'd0, 2'd1, 16'h8000, 16'h0, 1'b1);
    set_all(KERNEL_EPAN, 2, 4, 24'h01_0000, 32'h0001_0000);
    send_req(OP_QUERY, 10'd0, 2'd0, 16'h8000, 16'h0, 1'b1);
  endtask

  task automatic test_counts();
    set_all(KERNEL_GAUSS, 0, 1, 24'h01_0000, 32'h0001_0000);
    send_req(OP_QUERY, 10'd0, 2'd0, 16'h0, 16'h0, 1'b1);
    set_all(KERNEL_EPAN, 2, 0, 24'h01_0000, 32'h0002_0000);
    send_req(OP_QUERY, 10'd0, 2'd0, 16'h0, 16'h0, 1'b1);
    // opcode three carries no result, even with last set
    send_req(2'd3, 10'd5, 2'd2, 16'h1234, 16'h4321, 1'b1);
    send_req(2'd3, 10'd0, 2'd0, 16'h0, 16'h0, 1'b0);
  endtask

  task automatic test_full_store();
    // no dimensions in use, so the whole weight store is summed
    set_all(KERNEL_GAUSS, 2047, 0, 24'h00_8000, 32'h0000_0100);
    quiet = 1'b1;
    fill_missing();
    quiet = 1'b0;
    query_point(1'b0);
    set_all(KERNEL_EPAN, 1024, 0, 24'h00_4000, 32'h0000_1000);
    query_point(1'b0);
  endtask

  task automatic test_backpressure();
    set_all(KERNEL_GAUSS, 3, 2, 24'h01_0000, 32'h0001_0000);
    fill_missing();
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) query_point(1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int start, n;
    logic [23:0] bw;
    start = req_count;
    while (req_count - start < 480) begin
      case ($urandom_range(5))
        0:       bw = 24'($urandom);
        1:       bw = ($urandom_range(1)) ? 24'h0 : 24'hFF_FFFF;
        default: bw = 24'($urandom_range(32'h4_0000, 32'h4000));
      endcase
      if (req_count - start > 400) quiet = 1'b1;
      set_all(1'($urandom), ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1),
              $urandom_range(7), bw,
              ($urandom_range(5) == 0) ? $urandom : $urandom_range(32'h4_0000));
      fill_missing();
      n = $urandom_range(25, 12);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0, 1: send_req(OP_LOAD_COORD, 10'($urandom_range(15)), 2'($urandom),
                         ($urandom_range(1)) ? 16'($urandom) : near_coord(),
                         16'($urandom), 1'($urandom));
          2:    send_req(OP_LOAD_WEIGHT, 10'($urandom), 2'($urandom), 16'($urandom),
                         rand_weight(), 1'($urandom));
          3:    send_req(2'd3, 10'($urandom), 2'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom));
          default: query_point($urandom_range(4) == 0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_extremes();
    test_counts();
    test_backpressure();
    test_full_store();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("kernel_density_evaluation_tb: clean");
    end else begin
      $display("kernel_density_evaluation_tb: errors");
    end
    $finish;
  end

endmodule
